/* hdl/vttc_pkg.sv */
`default_nettype none
package vttc_pkg;
	localparam int MaxEntries = 32;
	localparam int IdxW = 5;
	localparam int CntW = 6;
	localparam logic [11:0] MaxVid = 12'd4094;
	localparam logic [15:0] TagEthertype = 16'h8100;
	localparam logic [15:0] RxOverhead = 16'd18;
	localparam logic [15:0] EthHdrBytes = 16'd14;
	localparam logic [16:0] TagBytes = 17'd4;

	localparam logic [2:0] ReqAdd = 3'd0;
	localparam logic [2:0] ReqDel = 3'd1;
	localparam logic [2:0] ReqRx = 3'd2;
	localparam logic [2:0] ReqTx = 3'd3;
	localparam logic [2:0] ReqRead = 3'd4;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] port;
		logic [11:0] vlan_id;
		logic [7:0] name_key;
		logic [15:0] ethertype_in;
		logic [15:0] tci_in;
		logic [15:0] frame_len;
		logic [15:0] max_len;
		logic [15:0] proto;
	} req_word_t;

	typedef struct packed {
		logic status;
		logic [5:0] entry_count;
		logic [11:0] out_tci;
		logic [15:0] out_ethertype;
		logic [16:0] out_length;
		logic [31:0] rx_packet_count;
		logic [31:0] rx_byte_count;
		logic [31:0] tx_packet_count;
		logic [31:0] tx_byte_count;
		logic [31:0] tx_drop_count;
	} rsp_word_t;

	typedef struct packed {
		logic [31:0] rx_pkts;
		logic [31:0] rx_octets;
		logic [31:0] tx_pkts;
		logic [31:0] tx_octets;
		logic [31:0] tx_discards;
	} ctr_t;
endpackage
`default_nettype wire

/* hdl/vlan_tag_table_with_counters_core.sv */
// VLAN table of 32 entries with per-entry counters. One request word in, one response word
// out. Each request passes a match step and then a write-back step before the output handshake:
// the match step compares the request against the entry tags held in flip-flops and issues a read
// of the entry's counters from a single-port synchronous memory; the write-back step forms the
// response and writes the updated counters back. The next request is taken once the response is
// in the output register and is not held there by a stalled receiver, never during write-back.
`default_nettype none
module vlan_tag_table_with_counters_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire vttc_pkg::req_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output vttc_pkg::rsp_word_t out_data
);
	import vttc_pkg::*;

	logic [MaxEntries-1:0] slot_valid_q;
	logic [3:0] slot_port_q [MaxEntries];
	logic [11:0] slot_vid_q [MaxEntries];
	logic [7:0] slot_key_q [MaxEntries];
	ctr_t ctr_mem [MaxEntries];
	ctr_t rd_s2;
	logic [CntW-1:0] total_q;

	logic busy_s2_q;
	req_word_t req_s2;
	logic hit_s2;
	logic [IdxW-1:0] idx_s2;
	logic add_ok_s2;

	logic accept;
	logic [MaxEntries-1:0] key_hit, pv_hit, rx_hit;
	logic key_any, pv_any, rx_any;
	logic [IdxW-1:0] key_idx, rx_idx, free_idx;
	logic free_any;

	assign in_ready = !busy_s2_q && !(out_valid && !out_ready);
	assign accept = in_valid && in_ready;

	always_comb begin
		key_any = 1'b0; pv_any = 1'b0; rx_any = 1'b0; free_any = 1'b0;
		key_idx = '0; rx_idx = '0; free_idx = '0;
		for (int i = MaxEntries - 1; i >= 0; i--) begin
			key_hit[i] = slot_valid_q[i] && slot_key_q[i] == in_data.name_key;
			pv_hit[i] = slot_valid_q[i] && slot_port_q[i] == in_data.port
				&& slot_vid_q[i] == in_data.vlan_id;
			rx_hit[i] = slot_valid_q[i] && slot_port_q[i] == in_data.port
				&& slot_vid_q[i] == in_data.tci_in[11:0];
			if (key_hit[i]) begin
				key_any = 1'b1; key_idx = IdxW'(i);
			end
			if (pv_hit[i]) pv_any = 1'b1;
			if (rx_hit[i]) begin
				rx_any = 1'b1; rx_idx = IdxW'(i);
			end
			if (!slot_valid_q[i]) begin
				free_any = 1'b1; free_idx = IdxW'(i);
			end
		end
	end

	logic hit_c, add_ok_c;
	logic [IdxW-1:0] idx_c;
	always_comb begin
		hit_c = 1'b0; add_ok_c = 1'b0; idx_c = key_idx;
		unique case (in_data.req_type)
			ReqAdd: begin
				add_ok_c = in_data.vlan_id != 12'd0 && in_data.vlan_id <= MaxVid
					&& free_any && !key_any && !pv_any;
				idx_c = free_idx;
			end
			ReqDel, ReqTx, ReqRead: hit_c = key_any;
			ReqRx: begin
				hit_c = rx_any && in_data.ethertype_in == TagEthertype
					&& in_data.frame_len >= RxOverhead;
				idx_c = rx_idx;
			end
			default: hit_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2_q <= 1'b0;
			slot_valid_q <= '0;
			total_q <= '0;
		end else begin
			busy_s2_q <= accept;
			if (accept && add_ok_c) begin
				slot_valid_q[idx_c] <= 1'b1;
				total_q <= total_q + 1'b1;
			end
			if (accept && hit_c && in_data.req_type == ReqDel) begin
				slot_valid_q[idx_c] <= 1'b0;
				total_q <= total_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s2 <= in_data;
			hit_s2 <= hit_c;
			idx_s2 <= idx_c;
			add_ok_s2 <= add_ok_c;
			rd_s2 <= ctr_mem[idx_c];
			if (add_ok_c) begin
				slot_port_q[idx_c] <= in_data.port;
				slot_vid_q[idx_c] <= in_data.vlan_id;
				slot_key_q[idx_c] <= in_data.name_key;
			end
		end
	end

	ctr_t upd;
	rsp_word_t rsp;
	logic wr_en;
	logic [16:0] nlen;
	always_comb begin
		upd = rd_s2;
		rsp = '0;
		wr_en = 1'b0;
		nlen = {1'b0, req_s2.frame_len} + TagBytes;
		rsp.status = 1'b1;
		rsp.entry_count = total_q;
		if (add_ok_s2) begin
			upd = '0;
			wr_en = 1'b1;
			rsp.status = 1'b0;
		end else if (hit_s2) begin
			unique case (req_s2.req_type)
				ReqRx: begin
					upd.rx_pkts = rd_s2.rx_pkts + 32'd1;
					upd.rx_octets = rd_s2.rx_octets + 32'(req_s2.frame_len - RxOverhead);
					wr_en = 1'b1;
					rsp.status = 1'b0;
				end
				ReqTx: begin
					if (nlen > {1'b0, req_s2.max_len}) begin
						upd.tx_discards = rd_s2.tx_discards + 32'd1;
						wr_en = 1'b1;
					end else if (req_s2.frame_len >= EthHdrBytes) begin
						upd.tx_pkts = rd_s2.tx_pkts + 32'd1;
						upd.tx_octets = rd_s2.tx_octets + 32'(nlen);
						wr_en = 1'b1;
						rsp.status = 1'b0;
						rsp.out_tci = slot_vid_q[idx_s2];
						rsp.out_ethertype = req_s2.proto;
						rsp.out_length = nlen;
					end
				end
				default: rsp.status = 1'b0;
			endcase
		end
		if ((hit_s2 && req_s2.req_type != ReqDel) || add_ok_s2) begin
			rsp.rx_packet_count = upd.rx_pkts;
			rsp.rx_byte_count = upd.rx_octets;
			rsp.tx_packet_count = upd.tx_pkts;
			rsp.tx_byte_count = upd.tx_octets;
			rsp.tx_drop_count = upd.tx_discards;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s2_q && wr_en) ctr_mem[idx_s2] <= upd;
		if (busy_s2_q) out_data <= rsp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (busy_s2_q) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
endmodule
`default_nettype wire

/* hdl/vttc_checker.sv */
`default_nettype none
module vttc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire vttc_pkg::rsp_word_t out_data
);
	import vttc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response dropped or changed while stalled");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken before the first response");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("response missing two cycles after a request");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= 6'(MaxEntries))
		else $error("entry count out of range");
	a_tag_on_success: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.out_length == 17'd0)
		else $error("tag length shown on a failed request");
endmodule

bind vlan_tag_table_with_counters_core vttc_checker u_vttc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
